@@ sv/qdws_pkg.sv @@
// qdws_pkg: shared types and constants of the quadrature decoder with speed unit
// used by qdws_speed_unit and quadrature_decoder_with_speed_unit; no dependencies
package qdws_pkg;

	localparam int SCALE_BITS = 20;
	// 60000 * 16, rpm in q.4
	localparam logic [SCALE_BITS-1:0] RPM_Q4_SCALE = 20'd960000;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_COUNTS_PER_REV   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD_MS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INDEX_ENABLE     = 2'd2;

	typedef logic signed [1:0] step_t;

	// x4 decode, indexed by {old a, old b, new a, new b}
	localparam step_t STEP_TABLE [16] = '{
		2'b00, 2'b01, 2'b11, 2'b00,
		2'b11, 2'b00, 2'b00, 2'b01,
		2'b01, 2'b00, 2'b00, 2'b11,
		2'b00, 2'b11, 2'b01, 2'b00
	};

	typedef struct packed {
		logic start;
		logic take;
	} unit_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

@@ sv/qdws_if.sv @@
// qdws_if: valid/ready channels for sample items and result items
// no dependencies
interface qdws_in_if;
	logic valid;
	logic ready;
	logic pin_a;
	logic pin_b;
	logic pin_z;
	logic ms_tick;
	logic clear_count;

	modport source (output valid, pin_a, pin_b, pin_z, ms_tick, clear_count, input ready);
	modport sink (input valid, pin_a, pin_b, pin_z, ms_tick, clear_count, output ready);
endinterface

interface qdws_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_count;
	logic signed [31:0] speed_rpm_q4;
	logic               speed_updated;

	modport source (output valid, position_count, speed_rpm_q4, speed_updated, input ready);
	modport sink (input valid, position_count, speed_rpm_q4, speed_updated, output ready);
endinterface

@@ sv/qdws_speed_unit.sv @@
// qdws_speed_unit: speed = delta * 960000 / den, truncated and saturated to 32 bits
// one shared adder runs a shift-add multiply, then a restoring divide; uses qdws_pkg
module qdws_speed_unit #(
	parameter int CountWidth = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  qdws_pkg::unit_ctrl_t   ctrl,
	input  logic [CountWidth-1:0]  delta,
	input  logic [31:0]            den,
	output qdws_pkg::unit_stat_t   stat,
	output logic [31:0]            speed
);

	localparam int NW = CountWidth + qdws_pkg::SCALE_BITS;
	localparam int AW = NW + 1;
	localparam int CW = $clog2(NW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic [CountWidth-1:0] mag_q;
	logic                  neg_q;
	logic                  zero_q;
	logic [31:0]           den_q;
	logic [NW-1:0]         acc_q;
	logic [31:0]           rem_q;
	logic [31:0]           quo_q;
	logic                  ovf_q;

	logic [AW-1:0] opa;
	logic [AW-1:0] opb;
	logic          cin;
	logic [AW-1:0] sum;
	logic          qbit;
	logic [31:0]   limit;
	logic [31:0]   res;

	// shared adder: accumulate in multiply, trial subtract in divide
	always_comb begin
		if (state_q == ST_DIV) begin
			opa = AW'({rem_q, acc_q[NW-1]});
			opb = ~AW'(den_q);
			cin = 1'b1;
		end else begin
			opa = AW'({acc_q[NW-2:0], 1'b0});
			opb = qdws_pkg::RPM_Q4_SCALE[cnt_q[4:0]] ? AW'(mag_q) : '0;
			cin = 1'b0;
		end
		sum = opa + opb + AW'(cin);
	end

	assign qbit = !sum[AW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_MUL;
						cnt_q   <= CW'(qdws_pkg::SCALE_BITS - 1);
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV;
						cnt_q   <= CW'(NW - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (ctrl.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					neg_q  <= delta[CountWidth-1];
					mag_q  <= delta[CountWidth-1] ? (~delta + 1'b1) : delta;
					zero_q <= (delta == '0);
					den_q  <= den;
					acc_q  <= '0;
					rem_q  <= '0;
					quo_q  <= '0;
					ovf_q  <= 1'b0;
				end
			end
			ST_MUL: begin
				acc_q <= sum[NW-1:0];
			end
			ST_DIV: begin
				rem_q <= qbit ? sum[31:0] : {rem_q[30:0], acc_q[NW-1]};
				acc_q <= {acc_q[NW-2:0], 1'b0};
				quo_q <= {quo_q[30:0], qbit};
				ovf_q <= ovf_q | quo_q[31];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		if (zero_q) begin
			res = '0;
		end else if (ovf_q || (quo_q > limit)) begin
			res = limit;
		end else begin
			res = quo_q;
		end
		speed = neg_q ? (~res + 1'b1) : res;
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

endmodule

@@ sv/quadrature_decoder_with_speed_unit.sv @@
// x4 quadrature decoder with periodic speed; one result item per sample item.
// an item without a speed recompute gives its result in the cycle after accept; an item
// recomputing speed waits for the shared multiply/divide unit and a free output.
// throughput: one item per cycle while no speed recompute runs and output is free; else none.
// reset: registers to their defaults, last ab = 3, last z = 1, counts and speed zero.
// uses qdws_pkg, qdws_if and qdws_speed_unit
module quadrature_decoder_with_speed_unit #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	qdws_in_if.sink                               samples,
	qdws_out_if.source                            results,
	input  logic                                  cfg_wen,
	input  logic [qdws_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [qdws_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [15:0]            cpr_q;
	logic [15:0]            period_q;
	logic                   index_en_q;
	logic [1:0]             last_ab_q;
	logic                   last_z_q;
	logic [COUNT_WIDTH-1:0] position_q;
	logic [COUNT_WIDTH-1:0] pos_sample_q;
	logic [15:0]            elapsed_q;
	logic [31:0]            speed_q;
	logic                   busy_q;
	logic                   out_valid_q;
	logic [31:0]            out_pos_q;
	logic [31:0]            out_speed_q;
	logic                   out_upd_q;

	logic                   take_in;
	logic                   out_free;
	logic                   load_done;
	logic [COUNT_WIDTH-1:0] pos_clr;
	logic [COUNT_WIDTH-1:0] pas_clr;
	logic [COUNT_WIDTH-1:0] pos_idx;
	logic [COUNT_WIDTH-1:0] pos_new;
	logic [63:0]            pos_new_ext;
	logic [63:0]            pos_cur_ext;
	qdws_pkg::step_t        step;
	logic [15:0]            el_inc;
	logic                   do_upd;
	logic [COUNT_WIDTH-1:0] delta;
	logic [31:0]            den;
	qdws_pkg::unit_ctrl_t   unit_ctrl;
	qdws_pkg::unit_stat_t   unit_stat;
	logic [31:0]            unit_speed;

	assign out_free      = !out_valid_q || results.ready;
	assign samples.ready = !busy_q && out_free;
	assign take_in       = samples.valid && samples.ready;
	assign load_done     = busy_q && unit_stat.done && out_free;

	always_comb begin
		pos_clr = samples.clear_count ? '0 : position_q;
		pas_clr = samples.clear_count ? '0 : pos_sample_q;
		pos_idx = (index_en_q && last_z_q && !samples.pin_z) ? '0 : pos_clr;
		step    = qdws_pkg::STEP_TABLE[{last_ab_q, samples.pin_a, samples.pin_b}];
		pos_new = pos_idx + {{(COUNT_WIDTH-2){step[1]}}, step};
		el_inc  = (samples.ms_tick && (elapsed_q != 16'hFFFF)) ? elapsed_q + 1'b1 : elapsed_q;
		do_upd  = (el_inc >= period_q) && (el_inc != '0);
		delta   = pos_new - pas_clr;
		den     = 32'(cpr_q) * 32'(el_inc);
	end

	assign pos_new_ext = 64'(signed'(pos_new));
	assign pos_cur_ext = 64'(signed'(position_q));

	assign unit_ctrl.start = take_in && do_upd;
	assign unit_ctrl.take  = load_done;

	qdws_speed_unit #(
		.CountWidth(COUNT_WIDTH)
	) u_speed (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (unit_ctrl),
		.delta (delta),
		.den   (den),
		.stat  (unit_stat),
		.speed (unit_speed)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q      <= 16'd2048;
			period_q   <= 16'd100;
			index_en_q <= 1'b1;
		end else if (cfg_wen) begin
			case (cfg_index)
				qdws_pkg::REG_COUNTS_PER_REV: begin
					cpr_q <= cfg_data;
				end
				qdws_pkg::REG_SAMPLE_PERIOD_MS: begin
					period_q <= cfg_data;
				end
				qdws_pkg::REG_INDEX_ENABLE: begin
					index_en_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ab_q    <= 2'b11;
			last_z_q     <= 1'b1;
			position_q   <= '0;
			pos_sample_q <= '0;
			elapsed_q    <= '0;
			speed_q      <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take_in) begin
				last_ab_q    <= {samples.pin_a, samples.pin_b};
				last_z_q     <= samples.pin_z;
				position_q   <= pos_new;
				pos_sample_q <= do_upd ? pos_new : pas_clr;
				elapsed_q    <= do_upd ? '0 : el_inc;
			end
			if (take_in && do_upd) begin
				busy_q <= 1'b1;
			end else if (load_done) begin
				busy_q  <= 1'b0;
				speed_q <= unit_speed;
			end
			if ((take_in && !do_upd) || load_done) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take_in && !do_upd) begin
			out_pos_q   <= pos_new_ext[31:0];
			out_speed_q <= speed_q;
			out_upd_q   <= 1'b0;
		end else if (load_done) begin
			out_pos_q   <= pos_cur_ext[31:0];
			out_speed_q <= unit_speed;
			out_upd_q   <= 1'b1;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.position_count = out_pos_q;
	assign results.speed_rpm_q4   = out_speed_q;
	assign results.speed_updated  = out_upd_q;

	a_busy_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(take_in))
		else $error("speed unit started without an item");

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !unit_stat.busy)
		else $error("speed unit running while decoder idle");

	a_updated_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.speed_updated |-> elapsed_q == '0)
		else $error("speed update without elapsed restart");

	a_speed_held: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.speed_updated |-> results.speed_rpm_q4 == speed_q)
		else $error("speed changed without update");

endmodule
